>>> sv/rplm_pkg.sv
// Package: field widths, operation codes and table entry types of the posting-list merge.
package rplm_pkg;

    localparam int OP_W    = 3;
    localparam int DOC_W   = 16;
    localparam int SCORE_W = 16;
    localparam int RANK_W  = 6;
    localparam int COUNT_W = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_AND   = 3'd1;
    localparam logic [OP_W-1:0] OP_END   = 3'd2;
    localparam logic [OP_W-1:0] OP_OR    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    // current table entry: mark bit, document, score
    typedef struct packed {
        logic               mark;
        logic [DOC_W-1:0]   doc;
        logic [SCORE_W-1:0] score;
    } t_cur_ent;

    // accumulated table entry
    typedef struct packed {
        logic [DOC_W-1:0]   doc;
        logic [SCORE_W-1:0] score;
    } t_acc_ent;

endpackage

>>> sv/rplm_if.sv
// Interfaces: request channel and result channel of the posting-list merge.
interface rplm_in_if;
    import rplm_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [DOC_W-1:0]   doc_id;
    logic [SCORE_W-1:0] occurrences;
    logic [RANK_W-1:0]  rank;

    modport source (output valid, op, doc_id, occurrences, rank, input ready);
    modport sink   (input valid, op, doc_id, occurrences, rank, output ready);
endinterface

interface rplm_out_if;
    import rplm_pkg::*;
    logic               valid;
    logic               ready;
    logic               status;
    logic [COUNT_W-1:0] entry_count;
    logic               found;
    logic [DOC_W-1:0]   out_doc;
    logic [SCORE_W-1:0] out_score;

    modport source (output valid, status, entry_count, found, out_doc, out_score, input ready);
    modport sink   (input valid, status, entry_count, found, out_doc, out_score, output ready);
endinterface

>>> sv/rplm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module rplm_ram #(
    parameter int W = 32,
    parameter int D = 64,
    localparam int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> sv/ranked_posting_list_merge.sv
// Top level: ranked posting-list merge sequencer over the current and accumulated tables.
// Each request yields one result. Both tables sit in RAMs with one read and one write port
// each, and the sequencer visits entries one at a time through that read port.
// An OR merge clears the mark bits of the current table, then, for each accumulated entry,
// scans the current table and adds the scores of its unmarked matches, saturating at
// SCORE_MAX; it then re-sorts the accumulated table stably and inserts the unmatched
// current entries. An AND entry with a lower score is removed and re-inserted.
// No clearing pass follows reset; the fill counts alone say which entries are live.
// A new request is taken while a finished result still waits at the output register.
module ranked_posting_list_merge #(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rplm_in_if.sink    i_req,
    rplm_out_if.source o_res
);
    import rplm_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam logic [FW-1:0] CAP_F = FW'(CAPACITY);
    localparam logic [FW-1:0] ONE_F = FW'(1);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_SH_RD, S_SH_CMP, S_SH_WR,
        S_AND_RD, S_AND_CHK, S_RM_RD, S_RM_WR,
        S_END_RD, S_END_CHK,
        S_CLR_RD, S_CLR_WR,
        S_OR_ARD, S_OR_AGET, S_OR_CRD, S_OR_CCHK,
        S_SORT_RD, S_SORT_GET,
        S_INS_RD, S_INS_CHK,
        S_RD_WAIT, S_DONE
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;

    logic [OP_W-1:0]    r_op, n_op;
    logic [DOC_W-1:0]   r_doc, n_doc;
    logic [SCORE_W-1:0] r_occ, n_occ;
    logic [RANK_W-1:0]  r_rank, n_rank;
    logic [FW-1:0]      r_acc_fill, n_acc_fill, r_cur_fill, n_cur_fill;
    logic [FW-1:0]      r_i, n_i, r_j, n_j, r_k, n_k, r_w, n_w;
    logic [SCORE_W-1:0] r_sum, n_sum;
    logic [DOC_W-1:0]   r_ndoc, n_ndoc;
    logic [SCORE_W-1:0] r_nsc, n_nsc;
    logic               r_nmk, n_nmk, r_strict, n_strict, r_tsel, n_tsel;
    logic               r_status, n_status, r_found, n_found;
    logic [DOC_W-1:0]   r_odoc, n_odoc;
    logic [SCORE_W-1:0] r_oscore, n_oscore;

    // output register
    logic               r_ov, n_ov;
    logic               r_o_status, n_o_status, r_o_found, n_o_found;
    logic [COUNT_W-1:0] r_o_count, n_o_count;
    logic [DOC_W-1:0]   r_o_doc, n_o_doc;
    logic [SCORE_W-1:0] r_o_score, n_o_score;

    // memory ports
    logic          cur_we, acc_we;
    logic [AW-1:0] cur_waddr, cur_raddr, acc_waddr, acc_raddr;
    t_cur_ent      cur_wdata, cur_rd;
    t_acc_ent      acc_wdata, acc_rd;

    logic [SCORE_W-1:0] sh_score;
    logic               sh_move;
    logic [SCORE_W:0]   sum_ext;
    logic [31:0]        rank_ext, fill_ext;

    function automatic logic [AW-1:0] adr(input logic [FW-1:0] x);
        return x[AW-1:0];
    endfunction

    rplm_ram #(.W($bits(t_cur_ent)), .D(CAPACITY)) u_cur_ram (
        .i_clk  (i_clk),
        .i_we   (cur_we),
        .i_waddr(cur_waddr),
        .i_wdata(cur_wdata),
        .i_raddr(cur_raddr),
        .o_rdata(cur_rd)
    );

    rplm_ram #(.W($bits(t_acc_ent)), .D(CAPACITY)) u_acc_ram (
        .i_clk  (i_clk),
        .i_we   (acc_we),
        .i_waddr(acc_waddr),
        .i_wdata(acc_wdata),
        .i_raddr(acc_raddr),
        .o_rdata(acc_rd)
    );

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_ov;
    assign o_res.status      = r_o_status;
    assign o_res.entry_count = r_o_count;
    assign o_res.found       = r_o_found;
    assign o_res.out_doc     = r_o_doc;
    assign o_res.out_score   = r_o_score;

    // shift step compare: strict for the stable re-sort, inclusive for inserts
    assign sh_score = r_tsel ? acc_rd.score : cur_rd.score;
    assign sh_move  = r_strict ? (sh_score < r_nsc) : (sh_score <= r_nsc);
    assign sum_ext  = {1'b0, r_sum} + {1'b0, cur_rd.score};
    assign rank_ext = 32'(r_rank);
    assign fill_ext = 32'(r_acc_fill);

    // sequencer next state and memory control
    always_comb begin
        n_state = r_state;   n_ret = r_ret;
        n_op = r_op;   n_doc = r_doc;   n_occ = r_occ;   n_rank = r_rank;
        n_acc_fill = r_acc_fill;   n_cur_fill = r_cur_fill;
        n_i = r_i;   n_j = r_j;   n_k = r_k;   n_w = r_w;   n_sum = r_sum;
        n_ndoc = r_ndoc;   n_nsc = r_nsc;   n_nmk = r_nmk;
        n_strict = r_strict;   n_tsel = r_tsel;
        n_status = r_status;   n_found = r_found;   n_odoc = r_odoc;   n_oscore = r_oscore;
        n_ov = r_ov && !o_res.ready;
        n_o_status = r_o_status;   n_o_found = r_o_found;   n_o_count = r_o_count;
        n_o_doc = r_o_doc;   n_o_score = r_o_score;
        cur_we = 1'b0;   cur_waddr = adr(r_k);   cur_wdata = cur_rd;   cur_raddr = adr(r_i);
        acc_we = 1'b0;   acc_waddr = adr(r_k);   acc_wdata = acc_rd;   acc_raddr = adr(r_i);

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op = i_req.op;   n_doc = i_req.doc_id;
                    n_occ = i_req.occurrences;   n_rank = i_req.rank;
                    n_status = STATUS_OK;   n_found = 1'b0;
                    n_odoc = '0;   n_oscore = '0;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (r_op)
                    OP_LOAD: begin
                        if (r_cur_fill == CAP_F) begin
                            n_status = STATUS_FULL;
                            n_state = S_DONE;
                        end else begin
                            n_ndoc = r_doc;   n_nsc = r_occ;   n_nmk = 1'b0;
                            n_tsel = 1'b0;   n_strict = 1'b0;
                            n_k = r_cur_fill;   n_cur_fill = r_cur_fill + ONE_F;
                            n_ret = S_DONE;   n_state = S_SH_RD;
                        end
                    end
                    OP_AND: begin
                        n_i = '0;   n_state = S_AND_RD;
                    end
                    OP_END: begin
                        n_i = '0;   n_w = '0;   n_state = S_END_RD;
                    end
                    OP_OR: begin
                        n_j = '0;   n_state = S_CLR_RD;
                    end
                    OP_READ: begin
                        if (rank_ext < fill_ext) begin
                            acc_raddr = rank_ext[AW-1:0];
                            n_found = 1'b1;
                            n_state = S_RD_WAIT;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_CLEAR: begin
                        n_acc_fill = '0;   n_cur_fill = '0;   n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            // shared sorted-insert loop: walk back from slot k, moving entries down
            S_SH_RD: begin
                if (r_k == '0) begin
                    n_state = S_SH_WR;
                end else begin
                    cur_raddr = adr(r_k - ONE_F);
                    acc_raddr = adr(r_k - ONE_F);
                    n_state = S_SH_CMP;
                end
            end
            S_SH_CMP: begin
                if (sh_move) begin
                    cur_we = !r_tsel;   acc_we = r_tsel;
                    n_k = r_k - ONE_F;
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cur_we = !r_tsel;   acc_we = r_tsel;
                cur_wdata = '{mark: r_nmk, doc: r_ndoc, score: r_nsc};
                acc_wdata = '{doc: r_ndoc, score: r_nsc};
                n_state = r_ret;
            end
            // and-term entry: mark matches, lower scores by remove and re-insert
            S_AND_RD: begin
                if (r_i < r_cur_fill) begin
                    n_state = S_AND_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_AND_CHK: begin
                if (cur_rd.doc == r_doc) begin
                    if (r_occ < cur_rd.score) begin
                        n_k = r_i;   n_state = S_RM_RD;
                    end else begin
                        cur_we = 1'b1;   cur_waddr = adr(r_i);
                        cur_wdata = '{mark: 1'b1, doc: cur_rd.doc, score: cur_rd.score};
                        n_i = r_i + ONE_F;   n_state = S_AND_RD;
                    end
                end else begin
                    n_i = r_i + ONE_F;   n_state = S_AND_RD;
                end
            end
            S_RM_RD: begin
                if ((r_k + ONE_F) < r_cur_fill) begin
                    cur_raddr = adr(r_k + ONE_F);
                    n_state = S_RM_WR;
                end else begin
                    // the fill count stays: the removal frees the last slot and the insert refills it
                    n_ndoc = r_doc;   n_nsc = r_occ;   n_nmk = 1'b1;
                    n_tsel = 1'b0;   n_strict = 1'b0;
                    n_k = r_cur_fill - ONE_F;
                    n_ret = S_AND_RD;   n_state = S_SH_RD;
                end
            end
            S_RM_WR: begin
                cur_we = 1'b1;
                n_k = r_k + ONE_F;   n_state = S_RM_RD;
            end
            // end of and-term: compact marked entries
            S_END_RD: begin
                if (r_i < r_cur_fill) begin
                    n_state = S_END_CHK;
                end else begin
                    n_cur_fill = r_w;   n_state = S_DONE;
                end
            end
            S_END_CHK: begin
                if (cur_rd.mark) begin
                    cur_we = 1'b1;   cur_waddr = adr(r_w);
                    cur_wdata = '{mark: 1'b0, doc: cur_rd.doc, score: cur_rd.score};
                    n_w = r_w + ONE_F;
                end
                n_i = r_i + ONE_F;   n_state = S_END_RD;
            end
            // or-merge: the mark bit serves as the used flag, cleared first
            S_CLR_RD: begin
                cur_raddr = adr(r_j);
                if (r_j < r_cur_fill) begin
                    n_state = S_CLR_WR;
                end else begin
                    n_i = '0;   n_state = S_OR_ARD;
                end
            end
            S_CLR_WR: begin
                cur_we = 1'b1;   cur_waddr = adr(r_j);
                cur_wdata = '{mark: 1'b0, doc: cur_rd.doc, score: cur_rd.score};
                n_j = r_j + ONE_F;   n_state = S_CLR_RD;
            end
            S_OR_ARD: begin
                if (r_i < r_acc_fill) begin
                    n_state = S_OR_AGET;
                end else begin
                    n_i = ONE_F;   n_state = S_SORT_RD;
                end
            end
            S_OR_AGET: begin
                n_sum = acc_rd.score;   n_ndoc = acc_rd.doc;
                n_j = '0;   n_state = S_OR_CRD;
            end
            S_OR_CRD: begin
                cur_raddr = adr(r_j);
                if (r_j < r_cur_fill) begin
                    n_state = S_OR_CCHK;
                end else begin
                    acc_we = 1'b1;   acc_waddr = adr(r_i);
                    acc_wdata = '{doc: r_ndoc, score: r_sum};
                    n_i = r_i + ONE_F;   n_state = S_OR_ARD;
                end
            end
            S_OR_CCHK: begin
                if (!cur_rd.mark && (cur_rd.doc == r_ndoc)) begin
                    cur_we = 1'b1;   cur_waddr = adr(r_j);
                    cur_wdata = '{mark: 1'b1, doc: cur_rd.doc, score: cur_rd.score};
                    n_sum = sum_ext[SCORE_W] ? SCORE_MAX : sum_ext[SCORE_W-1:0];
                end
                n_j = r_j + ONE_F;   n_state = S_OR_CRD;
            end
            // stable insertion sort of the summed table
            S_SORT_RD: begin
                if (r_i < r_acc_fill) begin
                    n_state = S_SORT_GET;
                end else begin
                    n_j = '0;   n_state = S_INS_RD;
                end
            end
            S_SORT_GET: begin
                n_ndoc = acc_rd.doc;   n_nsc = acc_rd.score;   n_nmk = 1'b0;
                n_tsel = 1'b1;   n_strict = 1'b1;
                n_k = r_i;   n_i = r_i + ONE_F;
                n_ret = S_SORT_RD;   n_state = S_SH_RD;
            end
            // insert unused current entries into the accumulated table
            S_INS_RD: begin
                cur_raddr = adr(r_j);
                if (r_j < r_cur_fill) begin
                    n_state = S_INS_CHK;
                end else begin
                    n_cur_fill = '0;   n_state = S_DONE;
                end
            end
            S_INS_CHK: begin
                n_j = r_j + ONE_F;
                n_state = S_INS_RD;
                if (!cur_rd.mark) begin
                    if (r_acc_fill == CAP_F) begin
                        n_status = STATUS_FULL;
                    end else begin
                        n_ndoc = cur_rd.doc;   n_nsc = cur_rd.score;   n_nmk = 1'b0;
                        n_tsel = 1'b1;   n_strict = 1'b0;
                        n_k = r_acc_fill;   n_acc_fill = r_acc_fill + ONE_F;
                        n_ret = S_INS_RD;   n_state = S_SH_RD;
                    end
                end
            end
            S_RD_WAIT: begin
                n_odoc = acc_rd.doc;   n_oscore = acc_rd.score;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || o_res.ready) begin
                    n_ov = 1'b1;
                    n_o_status = r_status;   n_o_found = r_found;
                    n_o_count = fill_ext[COUNT_W-1:0];
                    n_o_doc = r_odoc;   n_o_score = r_oscore;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_DONE;
            r_acc_fill <= '0;
            r_cur_fill <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_acc_fill <= n_acc_fill;
            r_cur_fill <= n_cur_fill;
            r_ov       <= n_ov;
        end
        r_op <= n_op;   r_doc <= n_doc;   r_occ <= n_occ;   r_rank <= n_rank;
        r_i <= n_i;   r_j <= n_j;   r_k <= n_k;   r_w <= n_w;   r_sum <= n_sum;
        r_ndoc <= n_ndoc;   r_nsc <= n_nsc;   r_nmk <= n_nmk;
        r_strict <= n_strict;   r_tsel <= n_tsel;
        r_status <= n_status;   r_found <= n_found;   r_odoc <= n_odoc;   r_oscore <= n_oscore;
        r_o_status <= n_o_status;   r_o_found <= n_o_found;   r_o_count <= n_o_count;
        r_o_doc <= n_o_doc;   r_o_score <= n_o_score;
    end

endmodule

>>> bench/ranked_posting_list_merge_tb.sv
// Testbench: checks the posting-list merge against an internal score-table predictor.
module ranked_posting_list_merge_tb;
    import rplm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 64;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] entry_count;
        logic               found;
        logic [DOC_W-1:0]   out_doc;
        logic [SCORE_W-1:0] out_score;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    rplm_in_if  req_if ();
    rplm_out_if res_if ();

    ranked_posting_list_merge #(.CAPACITY(CAP)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_res  (res_if.source)
    );

    // predicted table state
    logic [DOC_W-1:0]   acc_doc [CAP];
    logic [SCORE_W-1:0] acc_sc  [CAP];
    int                 acc_n;
    logic [DOC_W-1:0]   cur_doc [CAP];
    logic [SCORE_W-1:0] cur_sc  [CAP];
    logic               cur_mk  [CAP];
    int                 cur_n;

    t_result expected_q[$];
    int  fails;
    int  sent;
    int  checked;
    int  merges;
    int  drops;
    int  idle_cycles;
    bit  no_idle;
    bit  hold_off;

    // sorted insert into current table, ahead of equal scores
    function automatic bit cur_insert(logic [DOC_W-1:0] d, logic [SCORE_W-1:0] s, logic mk);
        int p;
        p = 0;
        if (cur_n >= CAP) return 0;
        while (p < cur_n && s < cur_sc[p]) p++;
        for (int k = cur_n; k > p; k--) begin
            cur_doc[k] = cur_doc[k-1];
            cur_sc[k]  = cur_sc[k-1];
            cur_mk[k]  = cur_mk[k-1];
        end
        cur_doc[p] = d;
        cur_sc[p]  = s;
        cur_mk[p]  = mk;
        cur_n++;
        return 1;
    endfunction

    function automatic bit acc_insert(logic [DOC_W-1:0] d, logic [SCORE_W-1:0] s);
        int p;
        p = 0;
        if (acc_n >= CAP) return 0;
        while (p < acc_n && s < acc_sc[p]) p++;
        for (int k = acc_n; k > p; k--) begin
            acc_doc[k] = acc_doc[k-1];
            acc_sc[k]  = acc_sc[k-1];
        end
        acc_doc[p] = d;
        acc_sc[p]  = s;
        acc_n++;
        return 1;
    endfunction

    function automatic void clear_marks();
        for (int k = 0; k < CAP; k++) cur_mk[k] = 1'b0;
    endfunction

    // work out the result of one request and update the tables
    function automatic t_result predict_result(logic [OP_W-1:0] op, logic [DOC_W-1:0] d,
                                               logic [SCORE_W-1:0] occ, logic [RANK_W-1:0] rk);
        t_result r;
        int i;
        int w;
        int j;
        int sum;
        bit used [CAP];
        logic [DOC_W-1:0]   td;
        logic [SCORE_W-1:0] ts;
        r = '0;
        case (op)
            OP_LOAD: begin
                if (!cur_insert(d, occ, 1'b0)) r.status = STATUS_FULL;
            end
            OP_AND: begin
                i = 0;
                while (i < cur_n) begin
                    if (cur_doc[i] == d) begin
                        if (occ < cur_sc[i]) begin
                            for (int k = i; k + 1 < cur_n; k++) begin
                                cur_doc[k] = cur_doc[k+1];
                                cur_sc[k]  = cur_sc[k+1];
                                cur_mk[k]  = cur_mk[k+1];
                            end
                            cur_n--;
                            void'(cur_insert(d, occ, 1'b1));
                            continue;
                        end
                        cur_mk[i] = 1'b1;
                    end
                    i++;
                end
            end
            OP_END: begin
                w = 0;
                for (i = 0; i < cur_n; i++) begin
                    if (cur_mk[i]) begin
                        cur_doc[w] = cur_doc[i];
                        cur_sc[w]  = cur_sc[i];
                        w++;
                    end
                end
                cur_n = w;
                clear_marks();
            end
            OP_OR: begin
                for (j = 0; j < CAP; j++) used[j] = 0;
                for (i = 0; i < acc_n; i++) begin
                    sum = acc_sc[i];
                    for (j = 0; j < cur_n; j++) begin
                        if (!used[j] && cur_doc[j] == acc_doc[i]) begin
                            used[j] = 1;
                            sum += cur_sc[j];
                            if (sum > SCORE_MAX) sum = SCORE_MAX;
                        end
                    end
                    acc_sc[i] = sum[SCORE_W-1:0];
                end
                // stable re-sort, descending
                for (i = 1; i < acc_n; i++) begin
                    td = acc_doc[i];
                    ts = acc_sc[i];
                    j = i;
                    while (j > 0 && acc_sc[j-1] < ts) begin
                        acc_doc[j] = acc_doc[j-1];
                        acc_sc[j]  = acc_sc[j-1];
                        j--;
                    end
                    acc_doc[j] = td;
                    acc_sc[j]  = ts;
                end
                for (j = 0; j < cur_n; j++)
                    if (!used[j] && !acc_insert(cur_doc[j], cur_sc[j])) r.status = STATUS_FULL;
                cur_n = 0;
                clear_marks();
                merges++;
            end
            OP_READ: begin
                if (rk < acc_n) begin
                    r.found     = 1'b1;
                    r.out_doc   = acc_doc[rk];
                    r.out_score = acc_sc[rk];
                end
            end
            OP_CLEAR: begin
                acc_n = 0;
                cur_n = 0;
                clear_marks();
            end
            default: ;
        endcase
        if (r.status == STATUS_FULL) drops++;
        r.entry_count = acc_n[COUNT_W-1:0];
        return r;
    endfunction

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // send one request, with random idle cycles before it; valid drops after it is taken
    task automatic send_request(logic [OP_W-1:0] op, logic [DOC_W-1:0] d,
                                logic [SCORE_W-1:0] occ, logic [RANK_W-1:0] rk);
        while (!no_idle && $urandom_range(99) < 23) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.op          <= op;
        req_if.doc_id      <= d;
        req_if.occurrences <= occ;
        req_if.rank        <= rk;
        do @(posedge i_clk); while (!req_if.ready);
        expected_q.push_back(predict_result(op, d, occ, rk));
        sent++;
        req_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side ready: random stalls, or a long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= no_idle || ($urandom_range(99) >= 23);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = {res_if.status, res_if.entry_count, res_if.found, res_if.out_doc,
                   res_if.out_score};
            checked++;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected");
                fails++;
            end else begin
                exp_r = expected_q.pop_front();
                if (got.status !== exp_r.status) begin
                    $error("status: expected %0d actual %0d", exp_r.status, got.status);
                    fails++;
                end
                if (got.entry_count !== exp_r.entry_count) begin
                    $error("entry_count: expected %0d actual %0d",
                           exp_r.entry_count, got.entry_count);
                    fails++;
                end
                if (got.found !== exp_r.found) begin
                    $error("found: expected %0d actual %0d", exp_r.found, got.found);
                    fails++;
                end
                if (got.out_doc !== exp_r.out_doc) begin
                    $error("out_doc: expected %0h actual %0h", exp_r.out_doc, got.out_doc);
                    fails++;
                end
                if (got.out_score !== exp_r.out_score) begin
                    $error("out_score: expected %0h actual %0h",
                           exp_r.out_score, got.out_score);
                    fails++;
                end
            end
        end
    end

    // watchdog: cycles with no request or result moving
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || hold_off) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("ranked_posting_list_merge test failed");
                $finish;
            end
        end
    end

    // directed: extremes of fields, every op, full tables, saturation
    task automatic test_directed();
        send_request(OP_READ, 16'h0, 16'h0, 6'd0);
        send_request(OP_LOAD, 16'hFFFF, 16'hFFFF, 6'h3F);
        send_request(OP_LOAD, 16'h0000, 16'h0000, 6'h00);
        send_request(OP_LOAD, 16'h1234, 16'hFFFF, 6'h00);
        send_request(OP_AND, 16'hFFFF, 16'hFFFF, 6'h00);
        send_request(OP_AND, 16'h1234, 16'h0001, 6'h00);
        send_request(OP_END, 16'h0, 16'h0, 6'h0);
        send_request(OP_OR, 16'h0, 16'h0, 6'h0);
        send_request(OP_LOAD, 16'hFFFF, 16'hFFFF, 6'h0);
        send_request(OP_OR, 16'h0, 16'h0, 6'h0);
        send_request(OP_READ, 16'h0, 16'h0, 6'd0);
        send_request(OP_READ, 16'h0, 16'h0, 6'd1);
        send_request(OP_READ, 16'h0, 16'h0, 6'h3F);
        send_request(OP_END, 16'h0, 16'h0, 6'h0);
        send_request(3'd6, 16'hAAAA, 16'h5555, 6'h2A);
        send_request(3'd7, 16'h5555, 16'hAAAA, 6'h15);
        send_request(OP_CLEAR, 16'h0, 16'h0, 6'h0);
        // fill both tables past capacity
        for (int k = 0; k < CAP + 2; k++) send_request(OP_LOAD, k[15:0], 16'd7, 6'h0);
        send_request(OP_OR, 16'h0, 16'h0, 6'h0);
        for (int k = 0; k < 3; k++) send_request(OP_LOAD, 16'h9000 + k[15:0], 16'd3, 6'h0);
        send_request(OP_OR, 16'h0, 16'h0, 6'h0);
        send_request(OP_READ, 16'h0, 16'h0, 6'h3F);
        send_request(OP_CLEAR, 16'h0, 16'h0, 6'h0);
    endtask

    // random queries: well-formed load / and / end / or sequences over small doc sets
    task automatic test_random_queries(int n_items);
        int terms;
        int n;
        logic [15:0] base;
        logic [15:0] span;
        while (sent < n_items) begin
            base = $urandom_range(0, 1) ? 16'hFFF0 : 16'($urandom_range(0, 65535));
            span = 16'($urandom_range(4, 24));
            if ($urandom_range(9) == 0) send_request(OP_CLEAR, 16'($urandom), 16'($urandom),
                                                     6'($urandom));
            n = $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
                send_request(OP_LOAD, base + 16'($urandom_range(0, span)),
                             16'($urandom), 6'($urandom));
            terms = $urandom_range(0, 2);
            for (int t = 0; t < terms; t++) begin
                n = $urandom_range(0, 10);
                for (int k = 0; k < n; k++)
                    send_request(OP_AND, base + 16'($urandom_range(0, span)),
                                 ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom),
                                 6'($urandom));
                send_request(OP_END, 16'($urandom), 16'($urandom), 6'($urandom));
            end
            if ($urandom_range(7) != 0)
                send_request(OP_OR, 16'($urandom), 16'($urandom), 6'($urandom));
            n = $urandom_range(0, 4);
            for (int k = 0; k < n; k++)
                send_request(OP_READ, 16'($urandom), 16'($urandom), 6'($urandom));
            // noise
            if ($urandom_range(4) == 0)
                send_request(3'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
        end
    endtask

    // receiver holds off while requests keep coming
    task automatic test_back_pressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int k = 0; k < 20; k++)
                    send_request(OP_READ, 16'($urandom), 16'($urandom), 6'($urandom));
            end
        join
    endtask

    task automatic wait_drain();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        fails = 0; sent = 0; checked = 0; merges = 0; drops = 0; idle_cycles = 0;
        no_idle = 1'b0; hold_off = 1'b0;
        acc_n = 0; cur_n = 0;
        clear_marks();
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.op = OP_LOAD;
        req_if.doc_id = '0;
        req_if.occurrences = '0;
        req_if.rank = '0;
        res_if.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_back_pressure();
        test_random_queries(700);
        no_idle = 1'b1;
        test_random_queries(1100);
        no_idle = 1'b0;
        test_random_queries(1530);
        wait_drain();
        $display("Covered %0d requests, %0d results checked, %0d OR merges, %0d drops.",
                 sent, checked, merges, drops);
        if (fails == 0) begin
            $display("ranked_posting_list_merge test passed");
        end else begin
            $display("ranked_posting_list_merge test failed");
        end
        $finish;
    end
endmodule

>>> ranked_posting_list_merge.f
sv/rplm_pkg.sv
sv/rplm_if.sv
sv/rplm_ram.sv
sv/ranked_posting_list_merge.sv
bench/ranked_posting_list_merge_tb.sv
